FILE: rtl/rtt_pkg.sv
// Range translation table package: sizes, status codes, function codes and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package rtt_pkg;
  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int Alignment = 256;
  localparam int AlignW = $clog2(Alignment);
  localparam int OffsetBits = 48;
  localparam logic [47:0] OffMask = 48'((65'd1 << OffsetBits) - 65'd1);

  localparam logic [1:0] FUNC_REG = 2'd0;
  localparam logic [1:0] FUNC_RESOLVE = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] REC_UNUSED = 2'd0;
  localparam logic [1:0] REC_ACTIVE = 2'd1;
  localparam logic [1:0] REC_RETIRED = 2'd2;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_BAD_NS = 4'd1;
  localparam logic [3:0] ST_BAD_SIZE = 4'd2;
  localparam logic [3:0] ST_BAD_BACKEND = 4'd3;
  localparam logic [3:0] ST_CAPACITY = 4'd4;
  localparam logic [3:0] ST_EXHAUSTED = 4'd5;
  localparam logic [3:0] ST_CROSS = 4'd6;
  localparam logic [3:0] ST_UNKNOWN = 4'd7;
  localparam logic [3:0] ST_STALE = 4'd8;
  localparam logic [3:0] ST_OOB = 4'd9;
  localparam logic [3:0] ST_INTERIOR = 4'd10;

  typedef struct packed {
    logic start;    // latch request, clear scan results
    logic scan;     // examine record rd_idx (read from scan_idx last cycle)
    logic rd_hit;   // issue read of the hit record
    logic finish;   // compute and register the result, commit writes
  } rtt_cmd_t;

  typedef struct packed {
    logic early;    // request resolved without a scan
  } rtt_stat_t;
endpackage

FILE: rtl/rtt_datapath.sv
// Range translation table datapath: record memory, status flags, scan
// results and result registers. Depends on rtt_pkg.
`timescale 1ns / 1ps
module rtt_datapath import rtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  rtt_cmd_t cmd,
  input  logic [IdxW-1:0] scan_idx,
  output rtt_stat_t stat,
  input  logic [15:0] ns,
  input  logic [5:0] max_alloc,
  input  logic [1:0] func,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic [63:0] remote_base,
  input  logic [63:0] size,
  input  logic [31:0] device,
  input  logic [1:0] alloc_type,
  output logic [3:0] status,
  output logic [63:0] alloc_virtual_base,
  output logic [63:0] alloc_backend_base,
  output logic [47:0] alloc_size,
  output logic [31:0] alloc_device,
  output logic [1:0] alloc_kind,
  output logic [63:0] translated,
  output logic [47:0] offset,
  output logic [5:0] active_count
);
  logic [47:0] mem_base [TableDepth];
  logic [63:0] mem_size [TableDepth];
  logic [63:0] mem_backend [TableDepth];
  logic [31:0] mem_device [TableDepth];
  logic [1:0] mem_kind [TableDepth];
  logic [1:0] rec_st [TableDepth];
  logic [47:0] next_offset;
  logic [CntW-1:0] active_total;

  logic [1:0] r_func;
  logic [63:0] r_addr, r_len, r_backend, r_size;
  logic [31:0] r_device;
  logic [1:0] r_kind;

  logic [47:0] rd_base;
  logic [63:0] rd_size, rd_backend;
  logic [31:0] rd_device;
  logic [1:0] rd_kind;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] rd_addr;

  logic act_hit, exact_hit, ret_hit, unused_hit, ret_any;
  logic [IdxW-1:0] act_idx, exact_idx, unused_idx, ret_idx;
  logic [47:0] ret_best;

  logic [47:0] a48;
  assign a48 = r_addr[47:0];

  // one registered read port
  assign rd_addr = cmd.rd_hit ? (r_func == FUNC_RELEASE && exact_hit ? exact_idx : act_idx)
                              : scan_idx;
  always_ff @(posedge clk) begin
    rd_base <= mem_base[rd_addr];
    rd_size <= mem_size[rd_addr];
    rd_backend <= mem_backend[rd_addr];
    rd_device <= mem_device[rd_addr];
    rd_kind <= mem_kind[rd_addr];
    rd_idx <= rd_addr;
  end

  logic in_rng;
  logic [47:0] diff;
  assign diff = a48 - rd_base;
  assign in_rng = (a48 >= rd_base) && ({16'd0, diff} < rd_size);

  // early status, decided from request, configuration and live-record count alone
  logic [3:0] early_st;
  logic early_v;
  always_comb begin
    early_v = 1'b1;
    early_st = ST_UNKNOWN;
    case (func)
      FUNC_REG: begin
        if (ns == 16'd0) early_st = ST_BAD_NS;
        else if (size == 64'd0) early_st = ST_BAD_SIZE;
        else if (remote_base == 64'd0) early_st = ST_BAD_BACKEND;
        else if ({{(8-CntW){1'b0}}, active_total} >= {2'd0, max_alloc} ||
                 32'(active_total) >= 32'(TableDepth)) early_st = ST_CAPACITY;
        else early_v = 1'b0;
      end
      FUNC_RESOLVE, FUNC_RELEASE: begin
        if (ns == 16'd0) early_st = ST_BAD_NS;
        else if (address[63:48] != ns) early_st = ST_CROSS;
        else early_v = 1'b0;
      end
      default: early_st = ST_UNKNOWN;
    endcase
  end
  assign stat.early = early_v;

  logic [3:0] r_early_st;
  logic r_early;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_func <= func; r_addr <= address; r_len <= length;
      r_backend <= remote_base; r_size <= size;
      r_device <= device; r_kind <= alloc_type;
      r_early <= early_v; r_early_st <= early_st;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_hit <= 1'b0; exact_hit <= 1'b0; ret_hit <= 1'b0;
      unused_hit <= 1'b0; ret_any <= 1'b0;
      act_idx <= '0; exact_idx <= '0; unused_idx <= '0; ret_idx <= '0;
      ret_best <= '0;
    end else if (cmd.scan) begin
      if (rec_st[rd_idx] == REC_ACTIVE && in_rng && !act_hit) begin
        act_hit <= 1'b1; act_idx <= rd_idx;
      end
      if (rec_st[rd_idx] == REC_ACTIVE && rd_base == a48 && !exact_hit) begin
        exact_hit <= 1'b1; exact_idx <= rd_idx;
      end
      if (rec_st[rd_idx] == REC_RETIRED && in_rng) ret_hit <= 1'b1;
      if (rec_st[rd_idx] == REC_UNUSED && !unused_hit) begin
        unused_hit <= 1'b1; unused_idx <= rd_idx;
      end
      if (rec_st[rd_idx] == REC_RETIRED && (!ret_any || rd_base < ret_best)) begin
        ret_any <= 1'b1; ret_idx <= rd_idx; ret_best <= rd_base;
      end
    end
  end

  // register path arithmetic
  logic [48:0] end_off, rounded;
  logic exhaust;
  assign end_off = {1'b0, next_offset} + r_size[48:0];
  assign exhaust = (r_size > {16'd0, OffMask - next_offset}) ||
                   (end_off > {1'b0, OffMask - 48'(Alignment - 1)});
  assign rounded = (end_off + 49'(Alignment - 1)) & ~49'(Alignment - 1);
  logic [IdxW-1:0] slot;
  assign slot = unused_hit ? unused_idx : ret_idx;

  // resolve arithmetic on the hit record (read registered by rd_hit)
  logic [47:0] hit_off;
  logic [64:0] xl_sum;
  assign hit_off = a48 - rd_base;
  assign xl_sum = {1'b0, rd_backend} + {17'd0, hit_off};

  logic [3:0] st_v;
  logic give_region, do_alloc, do_retire;
  always_comb begin
    st_v = r_early_st;
    give_region = 1'b0;
    do_alloc = 1'b0;
    do_retire = 1'b0;
    if (!r_early) begin
      case (r_func)
        FUNC_REG: begin
          if (exhaust) st_v = ST_EXHAUSTED;
          else if (!unused_hit && !ret_any) st_v = ST_CAPACITY;
          else begin st_v = ST_OK; do_alloc = 1'b1; end
        end
        FUNC_RESOLVE: begin
          if (!act_hit) st_v = ret_hit ? ST_STALE : ST_UNKNOWN;
          else begin
            give_region = 1'b1;
            if (r_len > rd_size - {16'd0, hit_off} || xl_sum[64]) st_v = ST_OOB;
            else st_v = ST_OK;
          end
        end
        FUNC_RELEASE: begin
          if (exact_hit) begin
            st_v = ST_OK; give_region = 1'b1; do_retire = 1'b1;
          end else if (act_hit) st_v = ST_INTERIOR;
          else st_v = ret_hit ? ST_STALE : ST_UNKNOWN;
        end
        default: st_v = ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && do_alloc) begin
      mem_base[slot] <= next_offset;
      mem_size[slot] <= r_size;
      mem_backend[slot] <= r_backend;
      mem_device[slot] <= r_device;
      mem_kind[slot] <= r_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TableDepth; i++) rec_st[i] <= REC_UNUSED;
      next_offset <= '0;
      active_total <= '0;
    end else if (cmd.finish) begin
      if (do_alloc) begin
        rec_st[slot] <= REC_ACTIVE;
        next_offset <= rounded[47:0];
        active_total <= active_total + 1'b1;
      end else if (do_retire) begin
        rec_st[exact_idx] <= REC_RETIRED;
        if (active_total != '0) active_total <= active_total - 1'b1;
      end
    end
  end

  logic alloc_now;
  assign alloc_now = do_alloc;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= st_v;
      alloc_virtual_base <= '0; alloc_backend_base <= '0; alloc_size <= '0;
      alloc_device <= '0; alloc_kind <= '0; translated <= '0; offset <= '0;
      if (alloc_now) begin
        alloc_virtual_base <= {ns, next_offset};
        alloc_backend_base <= r_backend;
        alloc_size <= r_size[47:0];
        alloc_device <= r_device;
        alloc_kind <= r_kind;
        active_count <= 6'(active_total + 1'b1);
      end else begin
        if (give_region) begin
          alloc_virtual_base <= {ns, rd_base};
          alloc_backend_base <= rd_backend;
          alloc_size <= rd_size[47:0];
          alloc_device <= rd_device;
          alloc_kind <= rd_kind;
        end
        if (!r_early && r_func == FUNC_RESOLVE && act_hit) offset <= hit_off;
        if (!r_early && r_func == FUNC_RESOLVE && st_v == ST_OK)
          translated <= xl_sum[63:0];
        if (do_retire && active_total != '0) active_count <= 6'(active_total - 1'b1);
        else active_count <= 6'(active_total);
      end
    end
  end
endmodule

FILE: rtl/rtt_ctrl.sv
// Range translation table controller: handshakes and scan sequencing.
// Depends on rtt_pkg.
`timescale 1ns / 1ps
module rtt_ctrl import rtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  rtt_stat_t stat,
  output rtt_cmd_t cmd,
  output logic [IdxW-1:0] scan_idx
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HIT = 3'd2;
  localparam logic [2:0] S_HITW = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state, state_next;
  logic [IdxW:0] cnt, cnt_next;
  logic early;

  assign in_ready = (state == S_IDLE);
  assign scan_idx = cnt[IdxW-1:0];

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.start = 1'b1;
        cnt_next = '0;
        state_next = stat.early ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        // data for index cnt-1 is on the read register
        if (cnt != '0) cmd.scan = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == (IdxW+1)'(TableDepth)) state_next = S_HIT;
      end
      S_HIT: begin cmd.rd_hit = 1'b1; state_next = S_HITW; end
      // keep the hit record on the read register for the finish cycle
      S_HITW: begin cmd.rd_hit = 1'b1; state_next = S_FIN; end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_OUT; end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
  assign early = 1'b0;
  assign out_valid = (state == S_OUT) && !early;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end
endmodule

FILE: rtl/range_translation_table_top.sv
// Range translation table top level: APB register file and the
// controller/datapath pair. Depends on rtt_pkg, rtt_ctrl, rtt_datapath.
`timescale 1ns / 1ps
// One request is taken at a time. A request settled without a scan (bad
// namespace, size, backend, capacity, cross session, unused function code)
// goes from the accepting state through S_FIN to S_OUT, where out_valid rises.
// Any other request walks the 32-entry record memory through its single
// registered read port, one record a cycle, rereads the hit record in S_HIT
// and S_HITW and forms the result in S_FIN; out_valid rises in S_OUT. The
// result stays on the outputs until its transfer and in_ready returns the
// cycle after. The namespace register sits at 0x0, the region limit register
// at 0x4 (reset 32). Records need no clearing pass: per-entry state flags
// reset.
module range_translation_table_top import rtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] func,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic [63:0] remote_base,
  input  logic [63:0] size,
  input  logic [31:0] device,
  input  logic [1:0] alloc_type,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] status,
  output logic [63:0] alloc_virtual_base,
  output logic [63:0] alloc_backend_base,
  output logic [47:0] alloc_size,
  output logic [31:0] alloc_device,
  output logic [1:0] alloc_kind,
  output logic [63:0] translated,
  output logic [47:0] offset,
  output logic [5:0] active_count
);
  localparam logic REG_NS = 1'b0;
  localparam logic REG_MAX = 1'b1;

  logic [15:0] ns;
  logic [5:0] max_alloc;
  rtt_cmd_t cmd;
  rtt_stat_t stat;
  logic [IdxW-1:0] scan_idx;

  assign pready = 1'b1;

  // registers decode on paddr[2]; low address bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      ns <= '0;
      max_alloc <= 6'd32;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NS: ns <= pwdata[15:0];
        REG_MAX: max_alloc <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NS: prdata = {16'd0, ns};
      REG_MAX: prdata = {26'd0, max_alloc};
      default: prdata = '0;
    endcase
  end

  rtt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd, .scan_idx
  );

  rtt_datapath u_dp (
    .clk, .rst, .cmd, .scan_idx, .stat, .ns, .max_alloc,
    .func, .address, .length, .remote_base, .size, .device, .alloc_type,
    .status, .alloc_virtual_base, .alloc_backend_base, .alloc_size,
    .alloc_device, .alloc_kind, .translated, .offset, .active_count
  );
endmodule

FILE: verif/range_translation_table_top_tb.sv
// Self-checking testbench for range_translation_table_top: directed table plus
// random register/resolve/release traffic, checked against an in-bench predictor.
// Depends on rtt_pkg and the RTL of range_translation_table_top.
`timescale 1ns / 1ps
module range_translation_table_top_tb import rtt_pkg::*;;

  localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused function code
  localparam logic [2:0] REG_NS     = 3'd0;
  localparam logic [2:0] REG_MAX    = 3'd4;
  localparam logic [15:0] NS_A      = 16'hA5C3;
  localparam logic [15:0] NS_X      = 16'h1234; // foreign namespace
  localparam int LIMIT_CYCLES       = 400000;
  localparam int PHASE_ITEMS        = 130;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] address;
    logic [63:0] length;
    logic [63:0] remote_base;
    logic [63:0] size;
    logic [31:0] device;
    logic [1:0]  alloc_type;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] vbase;
    logic [63:0] bbase;
    logic [47:0] rsize;
    logic [31:0] dev;
    logic [1:0]  kind;
    logic [63:0] xlat;
    logic [47:0] off;
    logic [5:0]  cnt;
  } resp_t;

  // directed row: request plus, where obvious, the status it must give
  typedef struct packed {
    req_t       req;
    logic       has_exp;
    logic [3:0] exp_status;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] func, alloc_type, alloc_kind;
  logic [63:0] address, length, remote_base, size;
  logic [31:0] device, alloc_device;
  logic [3:0] status;
  logic [63:0] alloc_virtual_base, alloc_backend_base, translated;
  logic [47:0] alloc_size, offset;
  logic [5:0] active_count;

  range_translation_table_top i_dut (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the translation table
  // ---------------------------------------------------------------------
  logic [47:0] rt_base    [TableDepth];
  logic [63:0] rt_size    [TableDepth];
  logic [63:0] rt_backend [TableDepth];
  logic [31:0] rt_device  [TableDepth];
  logic [1:0]  rt_kind    [TableDepth];
  logic [1:0]  rt_state   [TableDepth];
  logic [47:0] bump_ptr;
  int unsigned live_regions;
  logic [15:0] ns_reg;
  logic [5:0]  max_reg;

  resp_t expected_results[$];
  int    errors;
  bit    quiet;      // no idling on either side
  int    hold_off;   // receiver hold-off request, in cycles

  // record of state st that contains offset a, or -1
  function automatic int find_rec(logic [1:0] st, logic [47:0] a);
    for (int i = 0; i < TableDepth; i++)
      if (rt_state[i] == st && a >= rt_base[i] && {16'h0, a - rt_base[i]} < rt_size[i])
        return i;
    return -1;
  endfunction

  function automatic resp_t with_region(resp_t r, int i);
    r.vbase = {ns_reg, rt_base[i]};
    r.bbase = rt_backend[i];
    r.rsize = rt_size[i][47:0];
    r.dev   = rt_device[i];
    r.kind  = rt_kind[i];
    return r;
  endfunction

  function automatic logic [3:0] miss_status(logic [47:0] a);
    return (find_rec(REC_RETIRED, a) >= 0) ? ST_STALE : ST_UNKNOWN;
  endfunction

  // new record: lowest unused, else retired with lowest base
  function automatic int free_slot();
    int best;
    best = -1;
    for (int i = 0; i < TableDepth; i++)
      if (rt_state[i] == REC_UNUSED) return i;
    for (int i = 0; i < TableDepth; i++)
      if (rt_state[i] == REC_RETIRED && (best < 0 || rt_base[i] < rt_base[best]))
        best = i;
    return best;
  endfunction

  // Applies one request to the shadow table and returns the answer it must give.
  function automatic resp_t translate_request(req_t q);
    resp_t r;
    logic [47:0] a, off;
    logic [63:0] end_off;
    int i;
    r = '0;
    a = q.address[47:0];
    case (q.func)
      FUNC_REG: begin
        if (ns_reg == 16'h0) r.status = ST_BAD_NS;
        else if (q.size == 64'h0) r.status = ST_BAD_SIZE;
        else if (q.remote_base == 64'h0) r.status = ST_BAD_BACKEND;
        else if (live_regions >= max_reg || live_regions >= TableDepth) r.status = ST_CAPACITY;
        else if (q.size > {16'h0, OffMask - bump_ptr}) r.status = ST_EXHAUSTED;
        else begin
          end_off = {16'h0, bump_ptr} + q.size;
          i = free_slot();
          if (end_off > {16'h0, OffMask} - (Alignment - 1)) r.status = ST_EXHAUSTED;
          else if (i < 0) r.status = ST_CAPACITY;
          else begin
            rt_base[i]    = bump_ptr;
            rt_size[i]    = q.size;
            rt_backend[i] = q.remote_base;
            rt_device[i]  = q.device;
            rt_kind[i]    = q.alloc_type;
            rt_state[i]   = REC_ACTIVE;
            live_regions++;
            bump_ptr = 48'((end_off + (Alignment - 1)) & ~64'(Alignment - 1));
            r = with_region(r, i);
            r.status = ST_OK;
          end
        end
      end
      FUNC_RESOLVE: begin
        if (ns_reg == 16'h0) r.status = ST_BAD_NS;
        else if (q.address[63:48] != ns_reg) r.status = ST_CROSS;
        else begin
          i = find_rec(REC_ACTIVE, a);
          if (i < 0) r.status = miss_status(a);
          else begin
            off = a - rt_base[i];
            r = with_region(r, i);
            r.off = off;
            if (q.length > rt_size[i] - {16'h0, off}) r.status = ST_OOB;
            else if (rt_backend[i] > ~64'h0 - {16'h0, off}) r.status = ST_OOB;
            else begin
              r.xlat = rt_backend[i] + {16'h0, off};
              r.status = ST_OK;
            end
          end
        end
      end
      FUNC_RELEASE: begin
        if (ns_reg == 16'h0) r.status = ST_BAD_NS;
        else if (q.address[63:48] != ns_reg) r.status = ST_CROSS;
        else begin
          i = -1;
          for (int k = 0; k < TableDepth && i < 0; k++)
            if (rt_state[k] == REC_ACTIVE && rt_base[k] == a) i = k;
          if (i >= 0) begin
            r = with_region(r, i);
            rt_state[i] = REC_RETIRED;
            if (live_regions > 0) live_regions--;
            r.status = ST_OK;
          end else if (find_rec(REC_ACTIVE, a) >= 0) r.status = ST_INTERIOR;
          else r.status = miss_status(a);
        end
      end
      default: r.status = ST_UNKNOWN;
    endcase
    r.cnt = 6'(live_regions);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Random requests, often aimed at regions the table holds
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t random_request();
    req_t q;
    int held[$];
    int roll, i;
    logic [63:0] off;
    q = '0;
    for (int k = 0; k < TableDepth; k++)
      if (rt_state[k] != REC_UNUSED) held.push_back(k);
    roll = $urandom_range(0, 99);
    q.device     = $urandom;
    q.alloc_type = 2'($urandom);
    q.length     = 64'($urandom_range(0, 16));
    if (live_regions >= 24 && roll < 40) roll = 80;   // keep room in the table
    if (roll < 35) begin
      q.func = FUNC_REG;
      roll = $urandom_range(0, 99);
      if (roll < 80) q.size = 64'($urandom_range(1, 8192));
      else if (roll < 90) q.size = 64'($urandom);
      else if (roll < 95) q.size = 64'h0;
      else q.size = rand64();
      roll = $urandom_range(0, 99);
      if (roll < 90) q.remote_base = rand64();
      else if (roll < 95) q.remote_base = 64'h0;
      else q.remote_base = ~64'h0 - 64'($urandom_range(0, 4096));
    end else if (roll < 95) begin
      q.func = (roll < 70) ? FUNC_RESOLVE : FUNC_RELEASE;
      roll = $urandom_range(0, 99);
      if (held.size() > 0 && roll < 80) begin
        i = held[$urandom_range(0, held.size() - 1)];
        off = 64'h0;
        if (q.func == FUNC_RESOLVE || $urandom_range(0, 3) == 0)
          off = rand64() % (rt_size[i] + 64'd64);
        q.address = {ns_reg, rt_base[i] + off[47:0]};
        if (off <= rt_size[i]) q.length = rand64() % (rt_size[i] - off + 64'd2);
      end else if (roll < 90) begin
        off = rand64();
        q.address = {ns_reg, off[47:0]};
      end else q.address = rand64();
      if ($urandom_range(0, 9) == 0) q.length = rand64();
    end else begin
      q.func = FUNC_SPARE;
      q.address = rand64();
      q.size = rand64();
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // Driving: request channel, configuration port
  // ---------------------------------------------------------------------
  // in_ready is sampled mid-cycle so the accepting edge is seen without a race
  task automatic send_request(req_t q);
    logic acc;
    in_valid     <= 1'b1;
    func         <= q.func;
    address      <= q.address;
    length       <= q.length;
    remote_base  <= q.remote_base;
    size         <= q.size;
    device       <= q.device;
    alloc_type   <= q.alloc_type;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    expected_results.push_back(translate_request(q));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // sender pause: wait for every answer, then give the block time to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] a, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == REG_NS) ns_reg = d[15:0];
    else max_reg = d[5:0];
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    resp_t e;
    if (expected_results.size() == 0) begin
      report("unexpected transfer, status", 64'(status), 64'h0);
      return;
    end
    e = expected_results.pop_front();
    if (status != e.status) report("status", 64'(status), 64'(e.status));
    if (alloc_virtual_base != e.vbase) report("alloc_virtual_base", alloc_virtual_base, e.vbase);
    if (alloc_backend_base != e.bbase) report("alloc_backend_base", alloc_backend_base, e.bbase);
    if (alloc_size != e.rsize) report("alloc_size", 64'(alloc_size), 64'(e.rsize));
    if (alloc_device != e.dev) report("alloc_device", 64'(alloc_device), 64'(e.dev));
    if (alloc_kind != e.kind) report("alloc_kind", 64'(alloc_kind), 64'(e.kind));
    if (translated != e.xlat) report("translated", translated, e.xlat);
    if (offset != e.off) report("offset", 64'(offset), 64'(e.off));
    if (active_count != e.cnt) report("active_count", 64'(active_count), 64'(e.cnt));
  endtask

  // Receiver: checks each result transfer; stalls in bursts or on a hold-off.
  // The handshake is sampled mid-cycle; results hold across the transfer edge.
  initial begin
    int stall;
    logic fire;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      fire = !rst && out_valid && out_ready;
      @(posedge clk);
      if (fire) check_result();
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    for (int c = 0; c < LIMIT_CYCLES; c++) @(posedge clk);
    $display("** range_translation_table_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Directed table. First three rows run with the namespace still zero.
  // ---------------------------------------------------------------------
  localparam int NS_ZERO_ROWS = 3;
  localparam row_t DIRECTED [21] = '{
    '{'{FUNC_REG, 64'h0, 64'h0, 64'h1, 64'h10, 32'h0, 2'd0}, 1'b1, ST_BAD_NS},
    '{'{FUNC_RESOLVE, {NS_A, 48'h0}, 64'h1, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_BAD_NS},
    '{'{FUNC_SPARE, ~64'h0, ~64'h0, ~64'h0, ~64'h0, ~32'h0, 2'd3}, 1'b1, ST_UNKNOWN},
    // checks in order: size, then backend, then exhaustion
    '{'{FUNC_REG, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_BAD_SIZE},
    '{'{FUNC_REG, 64'h0, 64'h0, 64'h0, 64'h10, 32'h0, 2'd0}, 1'b1, ST_BAD_BACKEND},
    '{'{FUNC_REG, 64'h0, 64'h0, 64'h1, 64'h1_0000_0000_0000, 32'h0, 2'd0}, 1'b1, ST_EXHAUSTED},
    '{'{FUNC_REG, 64'h0, 64'h0, ~64'h0, ~64'h0, 32'h0, 2'd0}, 1'b1, ST_EXHAUSTED},
    // three regions: 0x0 (4 KiB), 0x1000 (1 byte), 0x1100 (backend near the top)
    '{'{FUNC_REG, 64'h0, 64'h0, 64'h1000_0000, 64'h1000, ~32'h0, 2'd3}, 1'b1, ST_OK},
    '{'{FUNC_REG, 64'h0, 64'h0, ~64'h0, 64'h1, 32'h0, 2'd0}, 1'b1, ST_OK},
    '{'{FUNC_REG, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FF80, 64'h100, 32'h5A5A, 2'd1},
      1'b1, ST_OK},
    '{'{FUNC_RESOLVE, {NS_A, 48'h10}, 64'h10, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b0, ST_OK},
    '{'{FUNC_RESOLVE, {NS_A, 48'h0}, 64'h1001, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_OOB},
    '{'{FUNC_RESOLVE, {NS_A, 48'h1000}, 64'h0, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b0, ST_OK},
    // backend base plus offset wraps past the top
    '{'{FUNC_RESOLVE, {NS_A, 48'h1180}, 64'h1, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_OOB},
    '{'{FUNC_RESOLVE, {NS_X, 48'h10}, 64'h1, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_CROSS},
    '{'{FUNC_RESOLVE, {NS_A, 48'h5000}, 64'h1, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_UNKNOWN},
    '{'{FUNC_RELEASE, {NS_A, 48'h10}, 64'h0, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_INTERIOR},
    '{'{FUNC_RELEASE, {NS_A, 48'h0}, 64'h0, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_OK},
    // retired region still held: stale, for resolve and for a second release
    '{'{FUNC_RESOLVE, {NS_A, 48'h10}, 64'h1, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_STALE},
    '{'{FUNC_RELEASE, {NS_A, 48'h0}, 64'h0, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_STALE},
    '{'{FUNC_RELEASE, {NS_X, 48'h1000}, 64'h0, 64'h0, 64'h0, 32'h0, 2'd0}, 1'b1, ST_CROSS}
  };

  // random phases: namespace and region limit for each
  localparam logic [15:0] PH_NS  [5] = '{16'hA5C3, 16'hFFFF, 16'h0001, 16'h5A3C, 16'h8000};
  localparam logic [5:0]  PH_MAX [5] = '{6'd32, 6'd1, 6'd0, 6'd17, 6'd32};

  initial begin
    req_t q;
    resp_t e;
    int waited;
    errors = 0;
    quiet = 1'b0;
    hold_off = 0;
    for (int i = 0; i < TableDepth; i++) begin
      rt_base[i] = '0; rt_size[i] = '0; rt_backend[i] = '0;
      rt_device[i] = '0; rt_kind[i] = '0; rt_state[i] = REC_UNUSED;
    end
    bump_ptr = '0;
    live_regions = 0;
    ns_reg = 16'h0;
    max_reg = 6'd32;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; func = '0; address = '0; length = '0; remote_base = '0;
    size = '0; device = '0; alloc_type = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int k = 0; k < $size(DIRECTED); k++) begin
      if (k == NS_ZERO_ROWS) begin
        drain();
        cfg_write(REG_NS, {16'h0, NS_A});
        cfg_write(REG_MAX, 32'd32);
      end
      send_request(DIRECTED[k].req);
      e = expected_results[$];
      if (DIRECTED[k].has_exp && e.status != DIRECTED[k].exp_status)
        report("directed row status", 64'(e.status), 64'(DIRECTED[k].exp_status));
    end

    // random phases, configuration changed between them while idle
    for (int p = 0; p < 5; p++) begin
      drain();
      cfg_write(REG_NS, {16'h0, PH_NS[p]});
      cfg_write(REG_MAX, {26'h0, PH_MAX[p]});
      if (p == 1) hold_off = 400;   // block fills up and stalls its input
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
    end

    // last part, no idling: empty the table, then run the offsets up to the top
    drain();
    quiet = 1'b1;
    cfg_write(REG_MAX, 32'd32);
    for (int i = 0; i < TableDepth; i++)
      if (rt_state[i] == REC_ACTIVE) begin
        q = '0;
        q.func = FUNC_RELEASE;
        q.address = {ns_reg, rt_base[i]};
        send_request(q);
      end
    q = '0;
    q.func = FUNC_REG;
    q.remote_base = rand64();
    q.device = $urandom;
    q.size = {16'h0, OffMask - 48'd511 - bump_ptr};
    send_request(q);
    for (int n = 0; n < 20; n++) begin
      q = random_request();
      if (q.func == FUNC_REG) q.size = (n % 2) ? 64'h1 : 64'h100;
      send_request(q);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** range_translation_table_top: PASSED **");
    end else begin
      $display("** range_translation_table_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rtt_pkg.sv
rtl/rtt_datapath.sv
rtl/rtt_ctrl.sv
rtl/range_translation_table_top.sv
verif/range_translation_table_top_tb.sv
